// File: rtl/framebuffer_glyph_renderer_defines.svh
// Assertion macros shared by the framebuffer glyph renderer RTL.
`ifndef FRAMEBUFFER_GLYPH_RENDERER_DEFINES_SVH
`define FRAMEBUFFER_GLYPH_RENDERER_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define FBGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define FBGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/fbgr_pkg.sv
// Package with the screen geometry, operation codes and glyph ROM of the renderer.
`timescale 1ns / 1ps

package fbgr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int PG_W          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LAST_ROWS     = SCREEN_HEIGHT - 8 * (PAGE_COUNT - 1);
  localparam logic [7:0] LAST_PAGE_MASK = 8'((1 << LAST_ROWS) - 1);

  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 7;
  localparam int CURSOR_ADVANCE = 6;
  localparam int CURSOR_COL_MAX = 511;
  localparam logic [GLYPH_ROWS-1:0] GLYPH_ROW_MASK = 7'h7F;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_CURSOR = 3'd1,
    OP_DRAW   = 3'd2,
    OP_PIXEL  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_cols_t;

  typedef struct packed {
    logic        found;
    glyph_cols_t cols;
  } glyph_t;

  function automatic glyph_cols_t glyph_pack(input logic [6:0] c0, input logic [6:0] c1,
                                             input logic [6:0] c2, input logic [6:0] c3,
                                             input logic [6:0] c4);
    glyph_cols_t res;
    res[0] = c0;
    res[1] = c1;
    res[2] = c2;
    res[3] = c3;
    res[4] = c4;
    return res;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t res;
    res.found = 1'b1;
    unique case (code)
      8'h30:   res.cols = glyph_pack(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
      8'h31:   res.cols = glyph_pack(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
      8'h32:   res.cols = glyph_pack(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
      8'h33:   res.cols = glyph_pack(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
      8'h34:   res.cols = glyph_pack(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
      8'h35:   res.cols = glyph_pack(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      8'h36:   res.cols = glyph_pack(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
      8'h37:   res.cols = glyph_pack(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      8'h38:   res.cols = glyph_pack(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      8'h39:   res.cols = glyph_pack(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
      8'h2E:   res.cols = glyph_pack(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
      8'h4C:   res.cols = glyph_pack(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
      8'h75:   res.cols = glyph_pack(7'h38, 7'h40, 7'h40, 7'h20, 7'h78);
      8'h78:   res.cols = glyph_pack(7'h44, 7'h28, 7'h10, 7'h28, 7'h44);
      default: begin
        res.found = 1'b0;
        res.cols  = '0;
      end
    endcase
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] fb_addr(input logic [PG_W-1:0] page,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(int'(page) * SCREEN_WIDTH + int'(col));
  endfunction

  function automatic logic [7:0] page_row_mask(input logic [PG_W-1:0] page);
    return (int'(page) == PAGE_COUNT - 1) ? LAST_PAGE_MASK : 8'hFF;
  endfunction

endpackage

// File: rtl/framebuffer_glyph_renderer.sv
// Top level of the page framebuffer with its 5x7 text renderer.
`timescale 1ns / 1ps
`include "framebuffer_glyph_renderer_defines.svh"

// The block holds a 128x64 one-bit framebuffer as 1024 column bytes in a RAM with one write
// and one registered read port, plus a text cursor, and returns one result per operation.
// It works on one operation at a time and accepts a new one while the previous result still
// waits on the output. A set cursor, set pixel, read or unknown operation passes straight to
// the result state. A drawn character streams its ten column bytes through the RAM at one
// read-modify-write per cycle, the write of one byte overlapping the read of the next. A
// character that is not in the ROM goes straight to the result state. A clear sweeps the RAM
// one byte per cycle. After reset the same sweep runs before the first operation is accepted.
module framebuffer_glyph_renderer import fbgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [9:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  char_code_i,
  input  logic        pixel_on_i,
  input  logic [9:0]  byte_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        glyph_found_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_DRAW   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(STORE_BYTES - 1);
  localparam logic [3:0]        STEP_LAST = 4'(2 * GLYPH_COLS - 1);

  state_e            state_q, state_d;
  logic              clr_boot_q, clr_boot_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [3:0]        step_q, step_d;

  logic signed [9:0] cur_col_q, cur_col_d;
  logic signed [7:0] cur_row_q, cur_row_d;
  logic signed [9:0] drw_col_q, drw_col_d;
  logic signed [7:0] drw_row_q, drw_row_d;
  glyph_cols_t       glyph_q, glyph_d;

  logic              rd_sel_q, rd_sel_d;
  logic              found_q, found_d;

  logic              wr_valid_q, wr_valid_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]        wr_bits_q, wr_bits_d;
  logic [7:0]        wr_mask_q, wr_mask_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        read_data_q, read_data_d;
  logic              glyph_found_q, glyph_found_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              in_xfer;
  logic              out_free;
  glyph_t            glyph_in;
  logic signed [10:0] adv_col;
  logic              px_ok;
  logic [7:0]        px_bit;
  logic signed [10:0] stp_x;
  logic signed [5:0] stp_pg;
  logic              stp_ok;
  logic [15:0]       stp_bits;
  logic [15:0]       stp_mask;
  logic [ADDR_W-1:0] stp_addr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign glyph_in   = glyph_lookup(char_code_i);

  assign adv_col = {cur_col_q[9], cur_col_q} + 11'(CURSOR_ADVANCE);

  assign px_ok  = !pos_x_i[9] && (pos_x_i < 10'(SCREEN_WIDTH)) &&
                  !pos_y_i[7] && (pos_y_i < 8'(SCREEN_HEIGHT));
  assign px_bit = 8'b1 << pos_y_i[2:0];

  assign stp_x    = {drw_col_q[9], drw_col_q} + 11'(step_q[3:1]);
  assign stp_pg   = {drw_row_q[7], drw_row_q[7:3]} + 6'(step_q[0]);
  assign stp_ok   = !stp_x[10] && (stp_x[9:0] < 10'(SCREEN_WIDTH)) &&
                    !stp_pg[5] && (stp_pg[4:0] < 5'(PAGE_COUNT));
  assign stp_bits = 16'(glyph_q[step_q[3:1]]) << drw_row_q[2:0];
  assign stp_mask = 16'(GLYPH_ROW_MASK) << drw_row_q[2:0];
  assign stp_addr = fb_addr(stp_pg[PG_W-1:0], stp_x[COL_W-1:0]);

  always_comb begin
    state_d       = state_q;
    clr_boot_d    = clr_boot_q;
    clr_cnt_d     = clr_cnt_q;
    step_d        = step_q;
    cur_col_d     = cur_col_q;
    cur_row_d     = cur_row_q;
    drw_col_d     = drw_col_q;
    drw_row_d     = drw_row_q;
    glyph_d       = glyph_q;
    rd_sel_d      = rd_sel_q;
    found_d       = found_q;
    wr_valid_d    = 1'b0;
    wr_addr_d     = wr_addr_q;
    wr_bits_d     = wr_bits_q;
    wr_mask_d     = wr_mask_q;
    out_valid_d   = out_valid_q && out_stall_i;
    read_data_d   = read_data_q;
    glyph_found_d = glyph_found_q;
    ram_re        = 1'b0;
    ram_raddr     = stp_addr;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          rd_sel_d = 1'b0;
          found_d  = 1'b0;
          state_d  = ST_FINISH;
          unique case (operation_i)
            OP_CLEAR: begin
              clr_boot_d = 1'b0;
              clr_cnt_d  = '0;
              state_d    = ST_CLEAR;
            end
            OP_CURSOR: begin
              cur_col_d = pos_x_i;
              cur_row_d = pos_y_i;
            end
            OP_DRAW: begin
              found_d   = glyph_in.found;
              glyph_d   = glyph_in.cols;
              drw_col_d = cur_col_q;
              drw_row_d = cur_row_q;
              step_d    = '0;
              cur_col_d = (adv_col > 11'(CURSOR_COL_MAX)) ? 10'(CURSOR_COL_MAX)
                                                          : adv_col[9:0];
              if (glyph_in.found) begin
                state_d = ST_DRAW;
              end
            end
            OP_PIXEL: begin
              wr_valid_d = px_ok;
              wr_addr_d  = fb_addr(PG_W'(pos_y_i[6:3]), pos_x_i[COL_W-1:0]);
              wr_bits_d  = pixel_on_i ? px_bit : 8'h00;
              wr_mask_d  = px_bit;
              ram_re     = px_ok;
              ram_raddr  = wr_addr_d;
            end
            OP_READ: begin
              rd_sel_d  = (int'(byte_index_i) < STORE_BYTES);
              ram_re    = rd_sel_d;
              ram_raddr = ADDR_W'(byte_index_i);
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = clr_boot_q ? ST_IDLE : ST_FINISH;
        end
      end
      ST_DRAW: begin
        ram_re     = stp_ok;
        wr_valid_d = stp_ok;
        wr_addr_d  = stp_addr;
        wr_bits_d  = step_q[0] ? stp_bits[15:8] : stp_bits[7:0];
        wr_mask_d  = (step_q[0] ? stp_mask[15:8] : stp_mask[7:0]) &
                     page_row_mask(stp_pg[PG_W-1:0]);
        step_d     = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          read_data_d   = rd_sel_q ? ram_rdata : 8'h00;
          glyph_found_d = found_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = wr_valid_q;
      ram_waddr = wr_addr_q;
      ram_wdata = (ram_rdata & ~wr_mask_q) | (wr_bits_q & wr_mask_q);
    end
  end

  fbgr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_boot_q  <= 1'b1;
      clr_cnt_q   <= '0;
      step_q      <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_boot_q  <= clr_boot_d;
      clr_cnt_q   <= clr_cnt_d;
      step_q      <= step_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      wr_valid_q  <= wr_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drw_col_q     <= drw_col_d;
    drw_row_q     <= drw_row_d;
    glyph_q       <= glyph_d;
    rd_sel_q      <= rd_sel_d;
    found_q       <= found_d;
    wr_addr_q     <= wr_addr_d;
    wr_bits_q     <= wr_bits_d;
    wr_mask_q     <= wr_mask_d;
    read_data_q   <= read_data_d;
    glyph_found_q <= glyph_found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign glyph_found_o = glyph_found_q;

  `FBGR_ASSERT(a_no_write_when_idle, (state_q == ST_IDLE) |-> !ram_we, "RAM written while idle")
  `FBGR_ASSERT(a_wr_pipe_state, wr_valid_q |-> (state_q == ST_DRAW || state_q == ST_FINISH), "Byte write outside a draw or pixel operation")
  `FBGR_ASSERT(a_step_bound, (state_q == ST_DRAW) |-> (step_q <= STEP_LAST), "Draw step counter out of range")
  `FBGR_ASSERT(a_result_exclusive, (out_valid_q && glyph_found_q) |-> (read_data_q == 8'h00), "Result carries both read data and a found glyph")

endmodule

// File: rtl/fbgr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fbgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/tb_framebuffer_glyph_renderer.sv
// Self-checking testbench for the page framebuffer with its 5x7 text renderer.
`timescale 1ns / 1ps

module tb_framebuffer_glyph_renderer;
  import fbgr_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_CMDS    = 900;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_EVERY = 350;
  localparam int HOLD_OFF_LEN   = 500;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]        op;
    logic signed [9:0] x;
    logic signed [7:0] y;
    logic [7:0]        code;
    logic              on;
    logic [9:0]        idx;
  } fb_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       found;
  } fb_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [2:0] drv_op = '0;
  logic [9:0] drv_x = '0;
  logic [7:0] drv_y = '0;
  logic [7:0] drv_code = '0;
  logic       drv_on = 1'b0;
  logic [9:0] drv_idx = '0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] read_data_o;
  logic       glyph_found_o;

  fb_cmd_t    cmd_q[$];
  fb_result_t pending_results[$];
  fb_cmd_t    cur_cmd;

  logic [7:0] frame_img [STORE_BYTES];
  int         cur_col = 0;
  int         cur_row = 0;

  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  string glyph_chars = "0123456789.Lux";

  framebuffer_glyph_renderer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (drv_op),
    .pos_x_i       (drv_x),
    .pos_y_i       (drv_y),
    .char_code_i   (drv_code),
    .pixel_on_i    (drv_on),
    .byte_index_i  (drv_idx),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data_o),
    .glyph_found_o (glyph_found_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [35:0] font_lookup(input logic [7:0] code);
    case (code)
      "0":     return {1'b1, 7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      "1":     return {1'b1, 7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
      "2":     return {1'b1, 7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
      "3":     return {1'b1, 7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
      "4":     return {1'b1, 7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
      "5":     return {1'b1, 7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
      "6":     return {1'b1, 7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      "7":     return {1'b1, 7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
      "8":     return {1'b1, 7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      "9":     return {1'b1, 7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      ".":     return {1'b1, 7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
      "L":     return {1'b1, 7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
      "u":     return {1'b1, 7'h78, 7'h20, 7'h40, 7'h40, 7'h38};
      "x":     return {1'b1, 7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
      default: return '0;
    endcase
  endfunction

  function automatic void put_px(input int x, input int y, input logic on);
    int idx;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
    idx = (y / 8) * SCREEN_WIDTH + x;
    frame_img[idx][y % 8] = on;
  endfunction

  function automatic fb_result_t render_cmd(input fb_cmd_t cmd);
    fb_result_t  res;
    logic [35:0] glyph;
    res.data  = 8'h00;
    res.found = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        foreach (frame_img[i]) frame_img[i] = 8'h00;
      end
      OP_CURSOR: begin
        cur_col = int'(cmd.x);
        cur_row = int'(cmd.y);
      end
      OP_DRAW: begin
        glyph = font_lookup(cmd.code);
        if (glyph[35]) begin
          res.found = 1'b1;
          for (int c = 0; c < GLYPH_COLS; c++)
            for (int r = 0; r < GLYPH_ROWS; r++)
              put_px(cur_col + c, cur_row + r, glyph[c * GLYPH_ROWS + r]);
        end
        if (cur_col + CURSOR_ADVANCE > CURSOR_COL_MAX) cur_col = CURSOR_COL_MAX;
        else cur_col = cur_col + CURSOR_ADVANCE;
      end
      OP_PIXEL: put_px(int'(cmd.x), int'(cmd.y), cmd.on);
      OP_READ: begin
        if (int'(cmd.idx) < STORE_BYTES) res.data = frame_img[cmd.idx];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Fields that the operation does not use get random values.
  task automatic add_cmd(input logic [2:0] op, input int x, input int y,
                         input logic [7:0] code, input logic on, input int idx);
    fb_cmd_t c;
    c.op   = op;
    c.x    = (op == OP_CURSOR || op == OP_PIXEL) ? 10'(x) : 10'($urandom);
    c.y    = (op == OP_CURSOR || op == OP_PIXEL) ? 8'(y) : 8'($urandom);
    c.code = (op == OP_DRAW) ? code : 8'($urandom);
    c.on   = (op == OP_PIXEL) ? on : 1'($urandom);
    c.idx  = (op == OP_READ) ? 10'(idx) : 10'($urandom);
    cmd_q.push_back(c);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      foreach (frame_img[i]) frame_img[i] = 8'h00;
    end else begin
      if (in_valid && !in_stall_o) begin
        pending_results.push_back(render_cmd(cur_cmd));
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
      end
      if (!in_valid || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          drv_op   <= cur_cmd.op;
          drv_x    <= cur_cmd.x;
          drv_y    <= cur_cmd.y;
          drv_code <= cur_cmd.code;
          drv_on   <= cur_cmd.on;
          drv_idx  <= cur_cmd.idx;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int         wait_n;
    fb_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      wait_n = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (out_valid_o && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Unexpected transfer: read_data %02h glyph_found %0b",
                     read_data_o, glyph_found_o);
        end else begin
          want = pending_results.pop_front();
          if (want.data !== read_data_o || want.found !== glyph_found_o) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("Result %0d: expected read_data %02h glyph_found %0b, got %02h %0b",
                       results_seen, want.data, want.found, read_data_o, glyph_found_o);
          end
        end
        results_seen++;
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        wait_n = rx_burst ? 0 : $urandom_range(0, 15);
        if (results_seen % HOLD_OFF_EVERY == 0) wait_n = HOLD_OFF_LEN;
      end
      rx_wait = wait_n;
      out_stall <= (wait_n != 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sel;
    int gcol;
    int grow;
    int gx;
    int gy;
    int rd_idx;

    add_cmd(OP_READ, 0, 0, 0, 1'b0, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, STORE_BYTES - 1);
    add_cmd(OP_PIXEL, 0, 0, 0, 1'b1, 0);
    add_cmd(OP_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 1'b1, 0);
    add_cmd(OP_PIXEL, -1, 0, 0, 1'b1, 0);
    add_cmd(OP_PIXEL, SCREEN_WIDTH, 5, 0, 1'b1, 0);
    add_cmd(OP_PIXEL, 3, SCREEN_HEIGHT, 0, 1'b1, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, STORE_BYTES - 1);
    add_cmd(OP_PIXEL, 0, 0, 0, 1'b0, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, 0);
    add_cmd(OP_CURSOR, -2, -3, 0, 1'b0, 0);
    add_cmd(OP_DRAW, 0, 0, "8", 1'b0, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, 1);
    add_cmd(OP_CURSOR, 124, 60, 0, 1'b0, 0);
    add_cmd(OP_DRAW, 0, 0, "0", 1'b0, 0);
    add_cmd(OP_DRAW, 0, 0, "A", 1'b0, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, 7 * SCREEN_WIDTH + 125);
    add_cmd(OP_CURSOR, 508, 127, 0, 1'b0, 0);
    add_cmd(OP_DRAW, 0, 0, "x", 1'b0, 0);
    add_cmd(OP_DRAW, 0, 0, "x", 1'b0, 0);
    add_cmd(OP_CURSOR, -512, -128, 0, 1'b0, 0);
    add_cmd(OP_UNUSED_LO, 0, 0, 0, 1'b0, 0);
    add_cmd(OP_CLEAR, 0, 0, 0, 1'b0, 0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0, 0);

    gcol = 0;
    grow = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        add_cmd(OP_CLEAR, 0, 0, 0, 1'b0, 0);
      end else if (sel < 12) begin
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
          gcol = $urandom_range(0, 1023) - 512;
          grow = $urandom_range(0, 255) - 128;
        end else if (sel < 4) begin
          gcol = $urandom_range(495, 511);
          grow = $urandom_range(0, 63);
        end else begin
          gcol = $urandom_range(0, 138) - 6;
          grow = $urandom_range(0, 74) - 8;
        end
        add_cmd(OP_CURSOR, gcol, grow, 0, 1'b0, 0);
      end else if (sel < 55) begin
        if ($urandom_range(0, 99) < 85)
          add_cmd(OP_DRAW, 0, 0, glyph_chars[$urandom_range(0, 13)], 1'b0, 0);
        else
          add_cmd(OP_DRAW, 0, 0, 8'($urandom), 1'b0, 0);
        gcol = (gcol + CURSOR_ADVANCE > CURSOR_COL_MAX) ? CURSOR_COL_MAX
                                                        : gcol + CURSOR_ADVANCE;
      end else if (sel < 72) begin
        if ($urandom_range(0, 9) == 0)
          add_cmd(OP_PIXEL, $urandom_range(0, 1023) - 512, $urandom_range(0, 255) - 128,
                  0, 1'($urandom), 0);
        else
          add_cmd(OP_PIXEL, $urandom_range(0, 135) - 4, $urandom_range(0, 71) - 4,
                  0, 1'($urandom), 0);
      end else if (sel < 97) begin
        gx = gcol + $urandom_range(0, 16) - 12;
        gy = grow + $urandom_range(0, 7);
        if ($urandom_range(0, 9) < 7 && gx >= 0 && gx < SCREEN_WIDTH &&
            gy >= 0 && gy < SCREEN_HEIGHT)
          rd_idx = (gy / 8) * SCREEN_WIDTH + gx;
        else
          rd_idx = $urandom_range(0, 1023);
        add_cmd(OP_READ, 0, 0, 0, 1'b0, rd_idx);
      end else begin
        add_cmd(OP_UNUSED_LO + 3'($urandom_range(0, OP_UNUSED_HI - OP_UNUSED_LO)),
                0, 0, 0, 1'b0, 0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
